### hw/rtl/mic_pkg.sv
// ----------------------------------------------------------------------------
// mic_pkg: shared types and constants for the multiset intersection counter
// Beat payloads, the queue entry between front and back, bank operation codes
// and the back-end state encoding.
// ----------------------------------------------------------------------------
package mic_pkg;

   localparam int unsigned VALUE_RANGE_DEF = 1024;
   localparam int unsigned MAX_ITEMS_DEF   = 2048;
   localparam int unsigned VALUE_W         = 10;
   localparam int unsigned COUNT_W         = 12;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam int unsigned QUEUE_DEPTH     = 4;

   typedef struct packed {
      logic [VALUE_W-1:0] value_a;
      logic [VALUE_W-1:0] value_b;
      logic               last_item;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] pair_count;
      logic               overflow;
   } rsp_type;

   // One classified item as the back end sees it.
   typedef struct packed {
      logic [VALUE_W-1:0] value_a;
      logic               count_a;
      logic [VALUE_W-1:0] value_b;
      logic               count_b;
      logic               last_item;
      logic               overflow;
   } queue_entry_type;

   typedef enum logic [1:0] {
      BANK_IDLE,
      BANK_INC,
      BANK_SWEEP
   } bank_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RUN,
      ST_DRAIN,
      ST_SCAN,
      ST_FINISH,
      ST_DELIVER
   } back_state_type;

endpackage

### hw/rtl/mic_front.sv
// ----------------------------------------------------------------------------
// mic_front: input beat acceptance and item classification
// Counts items of the current set, drops items past the limit and marks
// which values fall inside the histogram range.
// ----------------------------------------------------------------------------
module mic_front #(
   parameter int unsigned VALUE_RANGE = mic_pkg::VALUE_RANGE_DEF,
   parameter int unsigned MAX_ITEMS   = mic_pkg::MAX_ITEMS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mic_pkg::req_type         req_data,
   input  logic                     q_full,
   input  logic                     init_busy,
   output logic                     q_push,
   output mic_pkg::queue_entry_type q_data
);

   localparam int ITEM_W = $clog2(MAX_ITEMS + 1);

   logic [ITEM_W-1:0] items_seen_ff, items_seen_in;
   logic              overflow_ff, overflow_in;
   logic              limit_hit;

   assign req_ready = !q_full && !init_busy;
   assign q_push    = req_valid && req_ready;
   assign limit_hit = (32'(items_seen_ff) >= MAX_ITEMS);

   always_comb begin
      q_data.value_a   = req_data.value_a;
      q_data.value_b   = req_data.value_b;
      q_data.count_a   = !limit_hit && (32'(req_data.value_a) < VALUE_RANGE);
      q_data.count_b   = !limit_hit && (32'(req_data.value_b) < VALUE_RANGE);
      q_data.last_item = req_data.last_item;
      q_data.overflow  = overflow_ff || limit_hit;

      items_seen_in = items_seen_ff;
      overflow_in   = overflow_ff;
      if (q_push) begin
         if (req_data.last_item) begin
            items_seen_in = '0;
            overflow_in   = 1'b0;
         end else if (limit_hit) begin
            overflow_in = 1'b1;
         end else begin
            items_seen_in = items_seen_ff + ITEM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         items_seen_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         items_seen_ff <= items_seen_in;
         overflow_ff   <= overflow_in;
      end
   end

endmodule

### hw/rtl/mic_queue.sv
// ----------------------------------------------------------------------------
// mic_queue: short item queue between front and back
// A small first-in first-out buffer held in flops.
// ----------------------------------------------------------------------------
module mic_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mic_pkg::queue_entry_type push_data,
   input  logic                     pop,
   output mic_pkg::queue_entry_type pop_data,
   output logic                     full,
   output logic                     empty
);

   localparam int PTR_W = $clog2(mic_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(mic_pkg::QUEUE_DEPTH + 1);

   mic_pkg::queue_entry_type entry_ff [mic_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = (count_ff == CNT_W'(mic_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

### hw/rtl/mic_bank.sv
// ----------------------------------------------------------------------------
// mic_bank: one histogram memory with increment and sweep
// Increments run as read, then saturating add and write in the following cycle, with
// forwarding of the previous write. A sweep reads an entry and clears it.
// ----------------------------------------------------------------------------
module mic_bank #(
   parameter int unsigned VALUE_RANGE = mic_pkg::VALUE_RANGE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mic_pkg::bank_op_type               op,
   input  logic [$clog2(VALUE_RANGE)-1:0]     addr,
   output logic [mic_pkg::COUNT_W-1:0]        rd_count
);

   localparam int ADDR_W = $clog2(VALUE_RANGE);

   logic [mic_pkg::COUNT_W-1:0] mem [VALUE_RANGE];
   logic [mic_pkg::COUNT_W-1:0] rd_ff;
   logic                        s1_inc_ff;
   logic [ADDR_W-1:0]           s1_addr_ff;
   logic                        fwd_en_ff;
   logic [ADDR_W-1:0]           fwd_addr_ff;
   logic [mic_pkg::COUNT_W-1:0] fwd_data_ff;
   logic [mic_pkg::COUNT_W-1:0] old_count, new_count;

   assign rd_count = rd_ff;

   // The write of the previous increment lands on the same edge as this read.
   assign old_count = (fwd_en_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rd_ff;
   assign new_count = (old_count == mic_pkg::COUNT_MAX) ? old_count
                                                        : old_count + 1'b1;

   always_ff @(posedge clock) begin
      s1_addr_ff  <= addr;
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= new_count;
      if (op != mic_pkg::BANK_IDLE) begin
         rd_ff <= mem[addr];
      end
      if (s1_inc_ff) begin
         mem[s1_addr_ff] <= new_count;
      end else if (op == mic_pkg::BANK_SWEEP) begin
         mem[addr] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_inc_ff <= 1'b0;
         fwd_en_ff <= 1'b0;
      end else begin
         s1_inc_ff <= (op == mic_pkg::BANK_INC);
         fwd_en_ff <= s1_inc_ff;
      end
   end

endmodule

### hw/rtl/mic_back.sv
// ----------------------------------------------------------------------------
// mic_back: histogram sequencer, bin scan and result register
// Pops items into the two banks, runs the clearing sweep after reset and the
// summing scan after each last item, and holds the result beat.
// ----------------------------------------------------------------------------
module mic_back #(
   parameter int unsigned VALUE_RANGE = mic_pkg::VALUE_RANGE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  mic_pkg::queue_entry_type       q_data,
   output logic                           q_pop,
   output mic_pkg::bank_op_type           op_a,
   output logic [$clog2(VALUE_RANGE)-1:0] addr_a,
   input  logic [mic_pkg::COUNT_W-1:0]    count_a,
   output mic_pkg::bank_op_type           op_b,
   output logic [$clog2(VALUE_RANGE)-1:0] addr_b,
   input  logic [mic_pkg::COUNT_W-1:0]    count_b,
   output logic                           init_busy,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output mic_pkg::rsp_type               rsp_data
);

   localparam int ADDR_W = $clog2(VALUE_RANGE);
   localparam logic [ADDR_W-1:0] LAST_BIN = ADDR_W'(VALUE_RANGE - 1);

   mic_pkg::back_state_type     state_ff, state_in;
   logic [ADDR_W-1:0]           bin_ff, bin_in;
   logic                        ovf_ff, ovf_in;
   logic                        scan_vld_ff;
   logic [mic_pkg::COUNT_W-1:0] sum_ff, sum_in;
   logic [mic_pkg::COUNT_W-1:0] min_count;
   logic [mic_pkg::COUNT_W:0]   sum_wide;
   logic                        rsp_valid_ff;
   mic_pkg::rsp_type            rsp_data_ff;
   logic                        load_rsp;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign init_busy = (state_ff == mic_pkg::ST_CLEAR);

   assign min_count = (count_a < count_b) ? count_a : count_b;
   assign sum_wide  = {1'b0, sum_ff} + {1'b0, min_count};

   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      ovf_in   = ovf_ff;
      q_pop    = 1'b0;
      op_a     = mic_pkg::BANK_IDLE;
      op_b     = mic_pkg::BANK_IDLE;
      addr_a   = bin_ff;
      addr_b   = bin_ff;
      load_rsp = 1'b0;
      sum_in   = sum_ff;

      if (scan_vld_ff) begin
         sum_in = sum_wide[mic_pkg::COUNT_W] ? mic_pkg::COUNT_MAX
                                             : sum_wide[mic_pkg::COUNT_W-1:0];
      end

      case (state_ff)
         mic_pkg::ST_CLEAR, mic_pkg::ST_SCAN: begin
            op_a = mic_pkg::BANK_SWEEP;
            op_b = mic_pkg::BANK_SWEEP;
            if (bin_ff == LAST_BIN) begin
               bin_in   = '0;
               state_in = (state_ff == mic_pkg::ST_CLEAR) ? mic_pkg::ST_RUN
                                                          : mic_pkg::ST_FINISH;
            end else begin
               bin_in = bin_ff + ADDR_W'(1);
            end
         end
         mic_pkg::ST_RUN: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               op_a   = q_data.count_a ? mic_pkg::BANK_INC : mic_pkg::BANK_IDLE;
               op_b   = q_data.count_b ? mic_pkg::BANK_INC : mic_pkg::BANK_IDLE;
               addr_a = ADDR_W'(q_data.value_a);
               addr_b = ADDR_W'(q_data.value_b);
               if (q_data.last_item) begin
                  ovf_in   = q_data.overflow;
                  state_in = mic_pkg::ST_DRAIN;
               end
            end
         end
         mic_pkg::ST_DRAIN: begin
            state_in = mic_pkg::ST_SCAN;
         end
         mic_pkg::ST_FINISH: begin
            state_in = mic_pkg::ST_DELIVER;
         end
         mic_pkg::ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               sum_in   = '0;
               state_in = mic_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = mic_pkg::ST_CLEAR;
            bin_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mic_pkg::ST_CLEAR;
         bin_ff       <= '0;
         ovf_ff       <= 1'b0;
         scan_vld_ff  <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         bin_ff      <= bin_in;
         ovf_ff      <= ovf_in;
         scan_vld_ff <= (state_ff == mic_pkg::ST_SCAN);
         sum_ff      <= sum_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff.pair_count <= sum_ff;
         rsp_data_ff.overflow   <= ovf_ff;
      end
   end

endmodule

### hw/rtl/multiset_intersection_count.sv
// ----------------------------------------------------------------------------
// multiset_intersection_count: histogram intersection of two paired lists
// Counts the values of list A and list B in two histograms and, after the
// last beat of a set, returns the sum over bins of the smaller count.
// ----------------------------------------------------------------------------
// After reset the block sweeps both histograms to zero and holds req_ready
// low meanwhile. While a set is loading, it takes one request beat per cycle
// unless the queue is full: each beat increments one bin in each histogram
// through a read-then-write pipeline with forwarding, so repeated values in
// back-to-back beats count correctly. A beat with last_item set starts a scan
// of all bins, which reads and clears one bin of each histogram per cycle, and
// the result beat follows the scan. The length of the scan is set by the
// single read port of each histogram memory. During the scan the front end
// keeps accepting beats of the next set into a four-entry queue, and stalls
// only when that queue fills. Values at or above VALUE_RANGE are not counted.
// Beats past MAX_ITEMS in one set are dropped and flagged in the overflow bit
// of that set's result; bin counts and pair_count saturate at 4095.

module multiset_intersection_count #(
   parameter int unsigned VALUE_RANGE = mic_pkg::VALUE_RANGE_DEF,
   parameter int unsigned MAX_ITEMS   = mic_pkg::MAX_ITEMS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mic_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mic_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(VALUE_RANGE);

   // Front end to queue.
   logic                     q_push;
   mic_pkg::queue_entry_type q_push_data;
   logic                     q_full;

   // Queue to back end.
   logic                     q_pop;
   mic_pkg::queue_entry_type q_pop_data;
   logic                     q_empty;

   // Back end to histogram banks.
   mic_pkg::bank_op_type        op_a, op_b;
   logic [ADDR_W-1:0]           addr_a, addr_b;
   logic [mic_pkg::COUNT_W-1:0] count_a, count_b;

   logic init_busy;

   mic_front #(
      .VALUE_RANGE (VALUE_RANGE),
      .MAX_ITEMS   (MAX_ITEMS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .init_busy (init_busy),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   mic_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   mic_bank #(
      .VALUE_RANGE (VALUE_RANGE)
   ) u_bank_a (
      .clock    (clock),
      .reset    (reset),
      .op       (op_a),
      .addr     (addr_a),
      .rd_count (count_a)
   );

   mic_bank #(
      .VALUE_RANGE (VALUE_RANGE)
   ) u_bank_b (
      .clock    (clock),
      .reset    (reset),
      .op       (op_b),
      .addr     (addr_b),
      .rd_count (count_b)
   );

   mic_back #(
      .VALUE_RANGE (VALUE_RANGE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .op_a      (op_a),
      .addr_a    (addr_a),
      .count_a   (count_a),
      .op_b      (op_b),
      .addr_b    (addr_b),
      .count_b   (count_b),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### hw/rtl/mic_checker.sv
// ----------------------------------------------------------------------------
// mic_checker: port-level assertions for the multiset intersection counter
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module mic_checker #(
   parameter int unsigned MAX_ITEMS = mic_pkg::MAX_ITEMS_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input mic_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mic_pkg::rsp_type rsp_data
);

   // Sets whose last beat went in and whose result has not yet been taken.
   logic [3:0] open_sets_ff, open_sets_in;
   logic       last_in, rsp_out;

   assign last_in = req_valid && req_ready && req_data.last_item;
   assign rsp_out = rsp_valid && rsp_ready;

   always_comb begin
      open_sets_in = open_sets_ff;
      if (last_in && !rsp_out) begin
         open_sets_in = open_sets_ff + 4'd1;
      end else if (rsp_out && !last_in) begin
         open_sets_in = open_sets_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_sets_ff <= '0;
      end else begin
         open_sets_ff <= open_sets_in;
      end
   end

   // The clearing sweep keeps the request side closed right after reset.
   a_init_closed: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during the clearing sweep");

   a_result_has_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (open_sets_ff != 4'd0))
      else $error("result beat without a finished set");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.pair_count) <= MAX_ITEMS))
      else $error("pair count exceeds the item limit");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

endmodule

bind multiset_intersection_count mic_checker #(
   .MAX_ITEMS (MAX_ITEMS)
) u_mic_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
